/* sv/waypoint_follower_drive_unit_macros.svh */
// Assertion macros for the waypoint follower drive unit.
// Included by the top level only; depends on nothing else.
`ifndef WAYPOINT_FOLLOWER_DRIVE_UNIT_MACROS_SVH
`define WAYPOINT_FOLLOWER_DRIVE_UNIT_MACROS_SVH

// Same-cycle implication, held off while reset is asserted.
`define WFD_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, held off while reset is asserted.
`define WFD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/wfd_pkg.sv */
// Shared widths, codes and constants of the waypoint follower drive unit.
// No dependencies; every other file but the macro header imports it.
`default_nettype none

package wfd_pkg;

  localparam int COORD_W    = 12;
  localparam int DRIVE_W    = 14;
  localparam int TGT_W      = 6;
  localparam int PIDX_W     = 6;
  localparam int SENS_W     = 16;
  localparam int NPTS_W     = 7;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int AXIS_W     = 16;
  localparam int MUL_W      = 32;
  localparam int FRAC_W     = 12;

  localparam logic [CFG_IDX_W-1:0] CFG_SENSITIVITY = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_POINTS  = 2'd1;

  localparam logic [COORD_W-1:0] DEADBAND = 12'd10;
  localparam logic [COORD_W:0]   BOOST    = 13'd50;

  typedef enum logic {
    OP_LOAD     = 1'b0,
    OP_POSITION = 1'b1
  } opcode_t;

endpackage

`default_nettype wire

/* sv/wfd_in_if.sv */
// Input channel of the drive unit: valid/ready plus one command item.
// Depends on wfd_pkg.
`default_nettype none

interface wfd_in_if import wfd_pkg::*; ();
  logic                valid;
  logic                ready;
  opcode_t             opcode;
  logic [PIDX_W-1:0]   point_index;
  logic [COORD_W-1:0]  coord_x;
  logic [COORD_W-1:0]  coord_y;

  modport source (output valid, opcode, point_index, coord_x, coord_y, input ready);
  modport sink   (input valid, opcode, point_index, coord_x, coord_y, output ready);
endinterface

`default_nettype wire

/* sv/wfd_out_if.sv */
// Result channel of the drive unit: valid/ready plus one drive result.
// Depends on wfd_pkg.
`default_nettype none

interface wfd_out_if import wfd_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [DRIVE_W-1:0]  drive_x;
  logic signed [DRIVE_W-1:0]  drive_y;
  logic [TGT_W-1:0]           target_index;
  logic                       advanced;

  modport source (output valid, drive_x, drive_y, target_index, advanced, input ready);
  modport sink   (input valid, drive_x, drive_y, target_index, advanced, output ready);
endinterface

`default_nettype wire

/* sv/wfd_wpt_mem.sv */
// Waypoint table: one write port, one read port with registered read data.
// Depends on wfd_pkg.
`default_nettype none

module wfd_wpt_mem import wfd_pkg::*; #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic                   clk,
  input  logic                   we,
  input  logic [AW-1:0]          waddr,
  input  logic [2*COORD_W-1:0]   wdata,
  input  logic [AW-1:0]          raddr,
  output logic [2*COORD_W-1:0]   rdata_r
);

  logic [2*COORD_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

endmodule

`default_nettype wire

/* sv/wfd_mul.sv */
// Shared unsigned multiplier with a registered product.
// Depends on wfd_pkg.
`default_nettype none

module wfd_mul import wfd_pkg::*; (
  input  logic                 clk,
  input  logic                 en,
  input  logic [MUL_W-1:0]     a,
  input  logic [MUL_W-1:0]     b,
  output logic [2*MUL_W-1:0]   prod_r
);

  // The product only moves when a new operation is issued, so a result
  // may be held across a stall of the sequencer.
  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= a * b;
    end
  end

endmodule

`default_nettype wire

/* sv/waypoint_follower_drive_unit.sv */
// Waypoint follower drive unit, top level.
// Depends on wfd_pkg, wfd_in_if, wfd_out_if, wfd_wpt_mem, wfd_mul and the macro header.
//
// Usage. Items arrive on in_ch; each is one transaction. A load item (opcode 0)
// writes a waypoint into the table and sends the target back to entry 0. A
// position item (opcode 1) runs the advance test against the current and next
// waypoints and then produces signed drive values, 12 fraction bits, towards
// the (possibly new) target. Every item yields exactly one transaction on
// out_ch. Registers must be written through cfg_we/cfg_index/cfg_wdata only
// while the block is idle; the block itself does not enforce this.
//
// Sequence. A load item goes from acceptance straight to ST_FIN. A position
// item runs through ST_RDN, ST_SQ_AX, ST_SQ_BY, ST_SQ_OY, ST_SQ_NX, ST_LHS_A,
// ST_LHS_B, ST_RHS, ST_DEC, ST_DRV_X, ST_DRV_Y and ST_FIN. The steps are set
// by the single shared multiplier, which forms four squared differences,
// three products for the ellipse test and one reciprocal scaling per axis,
// plus the reads of the current and next waypoint through the one read port.
//
// Reset clears the target to 0, sensitivity and num_points to 1 and the
// output register to empty; the waypoint table is not cleared. A stalled
// receiver does not hold off acceptance: the finished result waits in the
// output register, and only a second result stalls in the final step.
`default_nettype none

module waypoint_follower_drive_unit import wfd_pkg::*; #(
  parameter int MAX_POINTS     = 64,
  parameter int ELLIPSE_AXIS_X = 400,
  parameter int ELLIPSE_AXIS_Y = 400,
  parameter int FULL_SCALE     = 240
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  wfd_in_if.sink                in_ch,
  wfd_out_if.source             out_ch
);

`include "waypoint_follower_drive_unit_macros.svh"

  // Table indexing; NW is wide enough for the point count and any index.
  localparam int IW    = $clog2(MAX_POINTS);
  localparam int CNT_W = $clog2(MAX_POINTS + 1);
  localparam int NW    = (CNT_W > NPTS_W) ? CNT_W : NPTS_W;
  localparam logic [NW-1:0] MAX_N = NW'(MAX_POINTS);

  // Ellipse test widths: squares, weighted sum and bound.
  localparam int SQ_W  = 2 * COORD_W;
  localparam int LHS_W = SQ_W + AXIS_W + 1;
  localparam int RHS_W = SENS_W + MUL_W;
  localparam logic [63:0] EXEY64 = 64'(ELLIPSE_AXIS_X) * 64'(ELLIPSE_AXIS_Y);
  localparam logic [MUL_W-1:0] EXEY = EXEY64[MUL_W-1:0];

  // Drive scaling: floor(N / FULL_SCALE) for N below 2**NUM_W is taken as
  // (N * RECIP) >> RSH, with RECIP rounded up; that is exact over the range.
  localparam int MAG_W  = COORD_W + 1;
  localparam int NUM_W  = COORD_W + FRAC_W;
  localparam int Q_W    = FRAC_W + 1;
  localparam int FS_L   = $clog2(FULL_SCALE);
  localparam int RSH    = NUM_W + FS_L;
  localparam logic [63:0] RECIP_NUM = 64'd1 << RSH;
  localparam logic [63:0] RECIP64 =
    (RECIP_NUM + 64'(FULL_SCALE) - 64'd1) / 64'(FULL_SCALE);
  localparam logic [MUL_W-1:0] RECIP = RECIP64[MUL_W-1:0];
  localparam logic [MAG_W-1:0] FS_M  = MAG_W'(FULL_SCALE);

  typedef enum logic [12:0] {
    ST_IDLE  = 13'b0000000000001,
    ST_RDN   = 13'b0000000000010,
    ST_SQ_AX = 13'b0000000000100,
    ST_SQ_BY = 13'b0000000001000,
    ST_SQ_OY = 13'b0000000010000,
    ST_SQ_NX = 13'b0000000100000,
    ST_LHS_A = 13'b0000001000000,
    ST_LHS_B = 13'b0000010000000,
    ST_RHS   = 13'b0000100000000,
    ST_DEC   = 13'b0001000000000,
    ST_DRV_X = 13'b0010000000000,
    ST_DRV_Y = 13'b0100000000000,
    ST_FIN   = 13'b1000000000000
  } state_t;

  function automatic logic [COORD_W-1:0] abs_diff(input logic [COORD_W-1:0] p,
                                                   input logic [COORD_W-1:0] q);
    abs_diff = (p > q) ? (p - q) : (q - p);
  endfunction

  // Control state.
  state_t            state_r, state_nxt;
  logic [IW-1:0]     target_r, target_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [SENS_W-1:0] sens_r;
  logic [NPTS_W-1:0] npts_r;

  // Working registers of one item.
  opcode_t             op_r;
  logic [COORD_W-1:0]  px_r, py_r;
  logic [IW-1:0]       nxt_r;
  logic [SQ_W-1:0]     old_xy_r, nxt_xy_r, tgt_xy_r;
  logic [SQ_W-1:0]     ax_r, by_r;
  logic [SQ_W:0]       dold_r;
  logic                closer_r;
  logic [LHS_W-1:0]    lhs_r;
  logic                adv_r;
  logic signed [DRIVE_W-1:0] drv_x_r;

  // Output register.
  logic signed [DRIVE_W-1:0] out_dx_r, out_dy_r;
  logic [TGT_W-1:0]          out_tgt_r;
  logic                      out_adv_r;

  logic in_acc, slot_free, is_load;
  logic [NW-1:0] npts_ext, n_use, old_p1, pidx_ext, tgt_ext;
  logic [IW-1:0] nxt_calc, rd_addr;
  logic          idx_ok, mem_we;
  logic [SQ_W-1:0] rd_data;
  logic [COORD_W-1:0] old_x, old_y, nxt_x, nxt_y, tgt_x, tgt_y;
  logic [COORD_W-1:0] sq_op, dxa, dya;
  logic [MAG_W-1:0]   mag_x, mx, my;
  logic [NUM_W-1:0]   num_x, num_y;
  logic               x_pos, y_pos;
  logic               mul_en;
  logic [MUL_W-1:0]   mul_a, mul_b;
  logic [2*MUL_W-1:0] prod;
  logic [Q_W-1:0]     q;
  logic [DRIVE_W-1:0] q_ext, q_neg;
  logic               adv_now;

  assign in_acc    = in_ch.valid && in_ch.ready;
  assign slot_free = !out_valid_r || out_ch.ready;
  assign is_load   = (in_ch.opcode == OP_LOAD);
  assign in_ch.ready = (state_r == ST_IDLE);

  // Points in use: zero counts as one, anything above the table as the table.
  assign npts_ext = NW'(npts_r);
  always_comb begin
    priority if (npts_ext == '0) begin
      n_use = NW'(1);
    end else if (npts_ext > MAX_N) begin
      n_use = MAX_N;
    end else begin
      n_use = npts_ext;
    end
  end

  // Next entry wraps to zero at the last entry in use, or beyond it.
  assign old_p1   = NW'(target_r) + NW'(1);
  assign nxt_calc = (old_p1 >= n_use) ? '0 : old_p1[IW-1:0];

  assign pidx_ext = NW'(in_ch.point_index);
  assign idx_ok   = (pidx_ext < MAX_N);
  assign mem_we   = in_acc && is_load && idx_ok;
  assign rd_addr  = (state_r == ST_RDN) ? nxt_r : target_r;
  assign tgt_ext  = NW'(target_r);

  wfd_wpt_mem #(
    .DEPTH (MAX_POINTS),
    .AW    (IW)
  ) u_mem (
    .clk     (clk),
    .we      (mem_we),
    .waddr   (pidx_ext[IW-1:0]),
    .wdata   ({in_ch.coord_x, in_ch.coord_y}),
    .raddr   (rd_addr),
    .rdata_r (rd_data)
  );

  assign old_x = old_xy_r[SQ_W-1:COORD_W];
  assign old_y = old_xy_r[COORD_W-1:0];
  assign nxt_x = nxt_xy_r[SQ_W-1:COORD_W];
  assign nxt_y = nxt_xy_r[COORD_W-1:0];
  assign tgt_x = tgt_xy_r[SQ_W-1:COORD_W];
  assign tgt_y = tgt_xy_r[COORD_W-1:0];

  // Drive magnitudes: the x axis gets a boost outside the dead band, both
  // are clamped to full scale and then shifted into the fraction field.
  assign dxa   = abs_diff(tgt_x, px_r);
  assign dya   = abs_diff(tgt_y, py_r);
  assign mag_x = {1'b0, dxa} + ((dxa > DEADBAND) ? BOOST : '0);
  assign mx    = (mag_x > FS_M) ? FS_M : mag_x;
  assign my    = ({1'b0, dya} > FS_M) ? FS_M : {1'b0, dya};
  assign num_x = {mx[COORD_W-1:0], {FRAC_W{1'b0}}};
  assign num_y = {my[COORD_W-1:0], {FRAC_W{1'b0}}};
  assign x_pos = (tgt_x > px_r);
  assign y_pos = (tgt_y > py_r);

  // Operand selection for the shared multiplier.
  always_comb begin
    mul_en = 1'b0;
    mul_a  = '0;
    mul_b  = '0;
    sq_op  = '0;
    unique case (state_r)
      ST_SQ_AX: begin
        sq_op  = abs_diff(px_r, old_x);
        mul_en = 1'b1;
      end
      ST_SQ_BY: begin
        sq_op  = abs_diff(py_r, nxt_y);
        mul_en = 1'b1;
      end
      ST_SQ_OY: begin
        sq_op  = abs_diff(py_r, old_y);
        mul_en = 1'b1;
      end
      ST_SQ_NX: begin
        sq_op  = abs_diff(px_r, nxt_x);
        mul_en = 1'b1;
      end
      ST_LHS_A: begin
        mul_en = 1'b1;
        mul_a  = MUL_W'(ax_r);
        mul_b  = MUL_W'(ELLIPSE_AXIS_Y);
      end
      ST_LHS_B: begin
        mul_en = 1'b1;
        mul_a  = MUL_W'(by_r);
        mul_b  = MUL_W'(ELLIPSE_AXIS_X);
      end
      ST_RHS: begin
        mul_en = 1'b1;
        mul_a  = MUL_W'(sens_r);
        mul_b  = EXEY;
      end
      ST_DRV_X: begin
        mul_en = 1'b1;
        mul_a  = MUL_W'(num_x);
        mul_b  = RECIP;
      end
      ST_DRV_Y: begin
        mul_en = 1'b1;
        mul_a  = MUL_W'(num_y);
        mul_b  = RECIP;
      end
      default: begin
      end
    endcase
    if (state_r == ST_SQ_AX || state_r == ST_SQ_BY ||
        state_r == ST_SQ_OY || state_r == ST_SQ_NX) begin
      mul_a = MUL_W'(sq_op);
      mul_b = MUL_W'(sq_op);
    end
  end

  wfd_mul u_mul (
    .clk    (clk),
    .en     (mul_en),
    .a      (mul_a),
    .b      (mul_b),
    .prod_r (prod)
  );

  // Scaled magnitude from the reciprocal product, and its negation.
  assign q     = prod[RSH +: Q_W];
  assign q_ext = DRIVE_W'(q);
  assign q_neg = (~q_ext) + DRIVE_W'(1);

  // Advance decision, taken once the bound has come out of the multiplier.
  assign adv_now = ({{(RHS_W-LHS_W){1'b0}}, lhs_r} <= prod[RHS_W-1:0]) &&
                   closer_r && (nxt_r != target_r);

  // Sequencer and target update.
  always_comb begin
    state_nxt     = state_r;
    target_nxt    = target_r;
    out_valid_nxt = out_valid_r;
    if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (is_load) begin
            target_nxt = '0;
            state_nxt  = ST_FIN;
          end else begin
            state_nxt  = ST_RDN;
          end
        end
      end
      ST_RDN:   state_nxt = ST_SQ_AX;
      ST_SQ_AX: state_nxt = ST_SQ_BY;
      ST_SQ_BY: state_nxt = ST_SQ_OY;
      ST_SQ_OY: state_nxt = ST_SQ_NX;
      ST_SQ_NX: state_nxt = ST_LHS_A;
      ST_LHS_A: state_nxt = ST_LHS_B;
      ST_LHS_B: state_nxt = ST_RHS;
      ST_RHS:   state_nxt = ST_DEC;
      ST_DEC: begin
        if (adv_now) begin
          target_nxt = nxt_r;
        end
        state_nxt = ST_DRV_X;
      end
      ST_DRV_X: state_nxt = ST_DRV_Y;
      ST_DRV_Y: state_nxt = ST_FIN;
      ST_FIN: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      target_r    <= '0;
      out_valid_r <= 1'b0;
      sens_r      <= SENS_W'(1);
      npts_r      <= NPTS_W'(1);
    end else begin
      state_r     <= state_nxt;
      target_r    <= target_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_SENSITIVITY: sens_r <= cfg_wdata[SENS_W-1:0];
          CFG_NUM_POINTS:  npts_r <= cfg_wdata[NPTS_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  // Working registers; each is loaded in the step that produces it.
  always_ff @(posedge clk) begin
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          op_r  <= in_ch.opcode;
          px_r  <= in_ch.coord_x;
          py_r  <= in_ch.coord_y;
          nxt_r <= nxt_calc;
        end
      end
      ST_RDN:   old_xy_r <= rd_data;
      ST_SQ_AX: nxt_xy_r <= rd_data;
      ST_SQ_BY: ax_r     <= prod[SQ_W-1:0];
      ST_SQ_OY: by_r     <= prod[SQ_W-1:0];
      ST_SQ_NX: dold_r   <= {1'b0, ax_r} + {1'b0, prod[SQ_W-1:0]};
      ST_LHS_A: closer_r <= (dold_r > ({1'b0, prod[SQ_W-1:0]} + {1'b0, by_r}));
      ST_LHS_B: lhs_r    <= prod[LHS_W-1:0];
      ST_RHS:   lhs_r    <= lhs_r + prod[LHS_W-1:0];
      ST_DEC: begin
        adv_r    <= adv_now;
        tgt_xy_r <= adv_now ? nxt_xy_r : old_xy_r;
      end
      ST_DRV_X: begin
      end
      ST_DRV_Y: drv_x_r <= x_pos ? q_ext : q_neg;
      ST_FIN: begin
        if (slot_free) begin
          out_tgt_r <= tgt_ext[TGT_W-1:0];
          if (op_r == OP_LOAD) begin
            out_dx_r  <= '0;
            out_dy_r  <= '0;
            out_adv_r <= 1'b0;
          end else begin
            out_dx_r  <= drv_x_r;
            out_dy_r  <= y_pos ? q_neg : q_ext;
            out_adv_r <= adv_r;
          end
        end
      end
      default: begin
      end
    endcase
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.drive_x      = out_dx_r;
  assign out_ch.drive_y      = out_dy_r;
  assign out_ch.target_index = out_tgt_r;
  assign out_ch.advanced     = out_adv_r;

  // The target never points outside the table.
  `WFD_ASSERT_NOW(a_target_in_table, clk, rst_n, 1'b1, tgt_ext < MAX_N, "target beyond table")
  // An accepted item keeps the input closed for at least the next cycle.
  `WFD_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_acc, !in_ch.ready, "ready after accept")
  // A load sends the target back to the first entry.
  `WFD_ASSERT_NEXT(a_load_clears_target, clk, rst_n, in_acc && is_load, target_r == '0, "load kept target")

endmodule

`default_nettype wire

/* tb/tb_top.sv */
// Self-checking testbench for the waypoint follower drive unit: loads waypoint tables,
// sends position samples and scores every drive transaction against its own prediction.
// Depends on wfd_pkg, wfd_in_if, wfd_out_if and the waypoint_follower_drive_unit RTL.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import wfd_pkg::*;

  // Build parameters of the unit as instantiated here (its defaults).
  localparam int MAX_POINTS = 64;
  localparam int AXIS_X     = 400;
  localparam int AXIS_Y     = 400;
  localparam int FULL_SCALE = 240;
  localparam int ONE_FIXED  = 1 << FRAC_W;
  localparam int COORD_MAX  = (1 << COORD_W) - 1;

  // The register port decodes two index bits but only two registers exist; the
  // remaining indices must swallow writes without effect.
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

  // How a position sample gets its coordinates. Fixed samples carry their own;
  // the others are placed near a waypoint when the driver issues them, because only
  // then is the target that the earlier transactions leave behind known.
  typedef enum logic [1:0] {
    AIM_FIXED,
    AIM_NEXT,
    AIM_TARGET
  } aim_t;

  typedef struct {
    opcode_t            op;
    logic [PIDX_W-1:0]  idx;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    aim_t               aim;
    int                 jitter;
  } command_t;

  typedef struct {
    logic signed [DRIVE_W-1:0] drive_x;
    logic signed [DRIVE_W-1:0] drive_y;
    logic [TGT_W-1:0]          target;
    logic                      advanced;
  } drive_t;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  wfd_in_if  in_ch ();
  wfd_out_if out_ch ();

  waypoint_follower_drive_unit i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  // Predicted state of the unit: waypoint table, current target and registers.
  logic [COORD_W-1:0] wp_x [MAX_POINTS];
  logic [COORD_W-1:0] wp_y [MAX_POINTS];
  logic [TGT_W-1:0]   cur_target;
  logic [SENS_W-1:0]  sensitivity;
  logic [NPTS_W-1:0]  num_points;

  command_t pending_cmds [$];    // commands not yet offered to the unit
  drive_t   drive_expected [$];  // predicted drive transactions, oldest first

  int errors;
  int n_loads;
  int n_positions;
  int n_advances;
  int n_cfg_writes;
  int n_phases;
  bit no_idle;                   // set for phases that run both sides flat out

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  // A count of zero behaves as one point and anything above the table size is
  // clipped to the table size.
  function automatic int unsigned points_in_use();
    if (num_points == 0) return 1;
    if (num_points > MAX_POINTS) return MAX_POINTS;
    return num_points;
  endfunction

  // Entry after the current target. It wraps to 0 after the last entry in use, and
  // also when the count has been lowered below the target.
  function automatic int unsigned next_entry();
    int unsigned n;
    n = points_in_use();
    return (cur_target + 1 >= n) ? 0 : cur_target + 1;
  endfunction

  function automatic longint sq_diff(logic [COORD_W-1:0] a, logic [COORD_W-1:0] b);
    longint da, db;
    da = a;
    db = b;
    return (da - db) * (da - db);
  endfunction

  // Magnitude to 12-bit fraction, saturating at full scale, truncated.
  function automatic logic [DRIVE_W-1:0] scaled(longint mag);
    if (mag > FULL_SCALE) mag = FULL_SCALE;
    return DRIVE_W'((mag * ONE_FIXED) / FULL_SCALE);
  endfunction

  // Applies one accepted command to the predicted state and returns the drive
  // transaction that it must produce.
  function automatic drive_t follow_waypoints(command_t c);
    drive_t             r;
    int unsigned        prev, nxt;
    longint             ax, by, d_old, d_new, mx, my;
    logic [COORD_W-1:0] tx, ty;
    r = '{default: '0};
    if (c.op == OP_LOAD) begin
      wp_x[c.idx] = c.x;
      wp_y[c.idx] = c.y;
      cur_target = '0;
    end else begin
      prev = cur_target;
      nxt = next_entry();
      // Ellipse test: x distance to the current point, y distance to the next one,
      // cross-multiplied so that no division is needed.
      ax = sq_diff(c.x, wp_x[prev]);
      by = sq_diff(c.y, wp_y[nxt]);
      d_old = ax + sq_diff(c.y, wp_y[prev]);
      d_new = sq_diff(c.x, wp_x[nxt]) + by;
      if (ax * AXIS_Y + by * AXIS_X <= longint'(sensitivity) * AXIS_X * AXIS_Y &&
          d_old > d_new && nxt != prev) begin
        cur_target = TGT_W'(nxt);
        r.advanced = 1'b1;
      end
      tx = wp_x[cur_target];
      ty = wp_y[cur_target];
      // Horizontal drive gets a boost outside the dead band; vertical drive is inverted.
      mx = (tx > c.x) ? tx - c.x : c.x - tx;
      if (mx > DEADBAND) mx += BOOST;
      r.drive_x = (tx > c.x) ? scaled(mx) : -scaled(mx);
      my = (ty > c.y) ? ty - c.y : c.y - ty;
      r.drive_y = (ty > c.y) ? -scaled(my) : scaled(my);
    end
    r.target = cur_target;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic int clamp_coord(int v);
    return (v < 0) ? 0 : (v > COORD_MAX) ? COORD_MAX : v;
  endfunction

  function automatic void queue_load(int idx, int x, int y);
    pending_cmds.insert(pending_cmds.size(),
                        '{op: OP_LOAD, idx: PIDX_W'(idx), x: COORD_W'(x),
                          y: COORD_W'(y), aim: AIM_FIXED, jitter: 0});
  endfunction

  function automatic void queue_position(int x, int y, aim_t aim = AIM_FIXED,
                                         int jitter = 0);
    pending_cmds.insert(pending_cmds.size(),
                        '{op: OP_POSITION, idx: PIDX_W'($urandom_range(0, 63)),
                          x: COORD_W'(x), y: COORD_W'(y), aim: aim, jitter: jitter});
  endfunction

  // Loads a run of consecutive entries with a path that mostly wanders in modest
  // steps and now and then jumps anywhere on the field.
  function automatic void queue_path(int first, int count);
    int x, y;
    x = $urandom_range(0, COORD_MAX);
    y = $urandom_range(0, COORD_MAX);
    for (int k = 0; k < count; k++) begin
      if ($urandom_range(0, 3) == 0) begin
        x = $urandom_range(0, COORD_MAX);
        y = $urandom_range(0, COORD_MAX);
      end else begin
        x = clamp_coord(x + int'($urandom_range(0, 1200)) - 600);
        y = clamp_coord(y + int'($urandom_range(0, 1200)) - 600);
      end
      queue_load((first + k) % MAX_POINTS, x, y);
    end
  endfunction

  // Mostly samples that close in on the next waypoint, so that the target walks
  // round the path; the rest hover round the target, land anywhere, or reload an
  // entry and thereby break the sequence.
  function automatic void queue_positions(int count);
    int roll;
    for (int k = 0; k < count; k++) begin
      roll = $urandom_range(0, 99);
      if (roll < 70)
        queue_position(0, 0, AIM_NEXT,
                       $urandom_range(0, 1) ? $urandom_range(0, 8) : $urandom_range(0, 200));
      else if (roll < 85)
        queue_position(0, 0, AIM_TARGET, $urandom_range(0, 300));
      else if (roll < 95)
        queue_position($urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX));
      else
        queue_load($urandom_range(0, MAX_POINTS - 1), $urandom_range(0, COORD_MAX),
                   $urandom_range(0, COORD_MAX));
    end
  endfunction

  // Places an aimed sample near its waypoint, using the state that all earlier
  // transactions have left in the prediction.
  function automatic command_t aim_command(command_t c);
    int unsigned e;
    int          off_x, off_y;
    if (c.op == OP_POSITION && c.aim != AIM_FIXED) begin
      e = (c.aim == AIM_NEXT) ? next_entry() : cur_target;
      off_x = int'($urandom_range(0, 2 * c.jitter)) - c.jitter;
      off_y = int'($urandom_range(0, 2 * c.jitter)) - c.jitter;
      c.x = COORD_W'(clamp_coord(int'(wp_x[e]) + off_x));
      c.y = COORD_W'(clamp_coord(int'(wp_y[e]) + off_y));
    end
    return c;
  endfunction

  // Register write through the plain write port. The unit is idle whenever this is
  // called, so the prediction can take the new value at once. It returns on a falling
  // edge so that the caller can queue commands without racing the driver.
  task automatic write_reg(logic [CFG_IDX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= index;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (index)
      CFG_SENSITIVITY: sensitivity = data[SENS_W-1:0];
      CFG_NUM_POINTS:  num_points  = data[NPTS_W-1:0];
      default: ;
    endcase
    n_cfg_writes++;
    @(negedge clk);
  endtask

  // Waits until every queued command has been taken and every predicted drive
  // transaction has come back, which leaves the unit idle.
  task automatic drain();
    do @(negedge clk);
    while (pending_cmds.size() != 0 || in_ch.valid || drive_expected.size() != 0);
  endtask

  function automatic void score_field(string field, logic signed [DRIVE_W-1:0] want,
                                      logic signed [DRIVE_W-1:0] got);
    if (got !== want) begin
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      errors++;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Clock and initial values
  // ---------------------------------------------------------------------------

  // Every input of the unit is given a known value before the first edge.
  initial begin
    clk = 1'b0;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    in_ch.valid = 1'b0;
    in_ch.opcode = OP_LOAD;
    in_ch.point_index = '0;
    in_ch.coord_x = '0;
    in_ch.coord_y = '0;
    out_ch.ready = 1'b0;
    forever #4 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Driver: offers one command per transaction and predicts its result as the
  // transaction completes. After each transaction it may hold valid low before
  // the next command, so that gaps fall on every stage of the unit's work.
  // ---------------------------------------------------------------------------
  command_t in_cmd;
  int       in_wait;

  always @(posedge clk) begin : driver
    bit     busy;
    drive_t r;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      in_wait = 0;
    end else begin
      busy = in_ch.valid && !in_ch.ready;
      if (in_ch.valid && in_ch.ready) begin
        r = follow_waypoints(in_cmd);
        drive_expected.insert(drive_expected.size(), r);
        if (in_cmd.op == OP_LOAD) n_loads++;
        else n_positions++;
        if (r.advanced) n_advances++;
        in_wait = no_idle ? 0 : $urandom_range(0, 9);
      end
      if (!busy) begin
        if (in_wait > 0) begin
          in_wait--;
          in_ch.valid <= 1'b0;
        end else if (pending_cmds.size() != 0) begin
          // Aiming happens here, once the previous transaction is already predicted.
          in_cmd = aim_command(pending_cmds.pop_front());
          in_ch.opcode      <= in_cmd.op;
          in_ch.point_index <= in_cmd.idx;
          in_ch.coord_x     <= in_cmd.x;
          in_ch.coord_y     <= in_cmd.y;
          in_ch.valid       <= 1'b1;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: takes each drive transaction and compares it field by field with the
  // oldest prediction. After each transaction the receiver may stall, which
  // exercises the unit's output register.
  // ---------------------------------------------------------------------------
  int out_wait;

  always @(posedge clk) begin : monitor
    drive_t want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      out_wait = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (drive_expected.size() == 0) begin
          $display("%0t ns: drive transaction with nothing expected, actual %0d %0d %0d %0d",
                   $time, out_ch.drive_x, out_ch.drive_y, out_ch.target_index,
                   out_ch.advanced);
          errors++;
        end else begin
          want = drive_expected.pop_front();
          score_field("drive_x", want.drive_x, out_ch.drive_x);
          score_field("drive_y", want.drive_y, out_ch.drive_y);
          score_field("target_index", DRIVE_W'(want.target),
                      DRIVE_W'(out_ch.target_index));
          score_field("advanced", DRIVE_W'(want.advanced), DRIVE_W'(out_ch.advanced));
        end
        out_wait = no_idle ? 0 : $urandom_range(0, 9);
      end
      if (out_wait > 0) begin
        out_wait--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    logic [SENS_W-1:0] sens_val;
    int                npts_val;
    // The prediction starts from the reset values of the registers and target;
    // the waypoint table is never read before it has been written.
    sensitivity = SENS_W'(1);
    num_points = NPTS_W'(1);
    cur_target = '0;
    errors = 0;
    n_loads = 0;
    n_positions = 0;
    n_advances = 0;
    n_cfg_writes = 0;
    n_phases = 0;
    no_idle = 1'b0;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed, reset settings: a single point, so the target can never move. The
    // samples probe zero drive, both sides of the x dead band in each direction, y
    // offsets alike, the exact full-scale magnitude and saturation in both directions.
    n_phases++;
    queue_load(0, 2000, 2000);
    queue_position(2000, 2000);
    queue_position(1990, 2000);
    queue_position(1989, 2000);
    queue_position(2010, 2000);
    queue_position(2011, 2000);
    queue_position(2000, 1990);
    queue_position(2000, 2011);
    queue_position(2190, 2000);
    queue_position(0, 0);
    queue_position(COORD_MAX, COORD_MAX);
    // Loads at the extremes of index and coordinates; each one sends the target home.
    queue_load(MAX_POINTS - 1, COORD_MAX, COORD_MAX);
    queue_load(1, 0, 0);
    queue_load(2, COORD_MAX, 0);
    queue_load(3, 0, COORD_MAX);
    drain();

    // Directed, four points and the widest ellipse: walk round the square corners.
    // Writes to the spare indices must change nothing.
    n_phases++;
    write_reg(CFG_NUM_POINTS, 16'd4);
    write_reg(CFG_SENSITIVITY, 16'hFFFF);
    write_reg(CFG_SPARE_A, 16'h5A5A);
    write_reg(CFG_SPARE_B, 16'hFFFF);
    queue_position(10, 10);
    queue_position(4000, 10);
    queue_position(10, 4000);
    drain();

    // The count drops below the target, so the next entry becomes entry 0; then a
    // wrap from the last point in use back to the first.
    n_phases++;
    write_reg(CFG_NUM_POINTS, 16'd2);
    queue_position(2000, 2000);
    queue_position(5, 5);
    queue_position(1990, 1995);
    drain();

    // A zero-size ellipse: a sample exactly on the axes ties on distance, and one
    // clearly nearer the next point still fails the ellipse test.
    n_phases++;
    write_reg(CFG_SENSITIVITY, 16'd0);
    queue_position(2000, 0);
    queue_position(500, 500);
    drain();

    // Random part. First fill the whole table with a path while the count is far
    // above the table size; every later phase may then use any count.
    n_phases++;
    write_reg(CFG_NUM_POINTS, 16'hFF7F);
    write_reg(CFG_SENSITIVITY, 16'($urandom_range(0, 65535)));
    queue_path(0, MAX_POINTS);
    queue_positions(40);
    drain();

    for (int phase = 1; phase <= 10; phase++) begin
      n_phases++;
      no_idle = (phase == 1) || ($urandom_range(0, 3) == 0);
      case ($urandom_range(0, 4))
        0:       sens_val = '0;
        1:       sens_val = '1;
        2:       sens_val = 16'($urandom_range(0, 1500));
        default: sens_val = 16'($urandom_range(0, 65535));
      endcase
      case ($urandom_range(0, 6))
        0:       npts_val = 0;
        1:       npts_val = 1;
        2:       npts_val = 2;
        3:       npts_val = MAX_POINTS;
        4:       npts_val = $urandom_range(MAX_POINTS + 1, 127);
        default: npts_val = $urandom_range(1, MAX_POINTS);
      endcase
      if (phase == 1) begin
        sens_val = '0;
        npts_val = 0;
      end
      if ($urandom_range(0, 3) == 0)
        write_reg($urandom_range(0, 1) ? CFG_SPARE_A : CFG_SPARE_B,
                  16'($urandom_range(0, 65535)));
      write_reg(CFG_SENSITIVITY, sens_val);
      // Junk above the seven count bits must be ignored.
      write_reg(CFG_NUM_POINTS, {9'($urandom_range(0, 511)), 7'(npts_val)});
      // Part of the path is sometimes relaid before the samples start.
      if ($urandom_range(0, 1))
        queue_path($urandom_range(0, MAX_POINTS - 1), $urandom_range(1, 6));
      queue_positions(60);
      drain();
    end

    // Let any stray transaction surface before the verdict.
    repeat (20) @(posedge clk);
    $display("Run covered %0d waypoint loads and %0d position samples, %0d of which moved",
             n_loads, n_positions, n_advances);
    $display("the target, with %0d register writes spread over %0d phases.",
             n_cfg_writes, n_phases);
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Watchdog: a correct run needs well under a quarter of this time.
  initial begin : watchdog
    #2ms;
    $display("Run timed out with %0d drive transactions outstanding.",
             drive_expected.size());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

/* sim.f */
+incdir+sv
sv/wfd_pkg.sv
sv/wfd_in_if.sv
sv/wfd_out_if.sv
sv/wfd_wpt_mem.sv
sv/wfd_mul.sv
sv/waypoint_follower_drive_unit.sv
tb/tb_top.sv
